### hdl/lvgt_pkg.sv
// lvgt_pkg: shared constants, register indexes and divider status type
// for the local variance gated threshold block. No dependencies.
package lvgt_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WINDOW_DEF    = 7;

    localparam int PIX_W  = 8;
    localparam int FW_W   = 11;
    localparam int FH_W   = 16;
    localparam int VL_W   = 16;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;
    localparam logic [VL_W-1:0] VL_RESET = 16'd1000;

    localparam logic FUNC_PIXEL = 1'b0;

    typedef enum logic [1:0]
    {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_VLIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hdl/lvgt_line_mem.sv
// lvgt_line_mem: line store, one write port and one registered read port.
// Depends on nothing.
module lvgt_line_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lvgt_div.sv
// lvgt_div: restoring divider, one quotient bit per cycle.
// Depends on lvgt_pkg (div_status_t).
module lvgt_div #(
    parameter int N = 22,
    parameter int D = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [N-1:0]           dividend,
    input  logic [D-1:0]           divisor,
    output logic [N-1:0]           quotient,
    output lvgt_pkg::div_status_t  status
);

    localparam int CW = $clog2(N + 1);

    logic [D-1:0]  rem_reg;
    logic [N-1:0]  quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [D:0]    trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? D'(trial - {1'b0, divisor}) : D'(trial);
            quo_reg <= {quo_reg[N-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### hdl/local_variance_gated_threshold.sv
// A word that completes a window gives its result after two scans of the window
// through the line store read port and two passes of the shared bit-serial
// divider. One word at a time; other words go from ST_CHECK back to ST_IDLE.
// Reset (rst_n, async, low) clears positions, hold and registers to defaults;
// the line store has no clearing pass and is only read where already written.
module local_variance_gated_threshold #(
    parameter int MAX_WIDTH = lvgt_pkg::MAX_WIDTH_DEF,
    parameter int WINDOW    = lvgt_pkg::WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // pixel[7:0]
    input  logic                       s_tuser,   // func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // white, zeros
    output logic                       m_tlast,   // row_end
    output logic                       m_tuser,   // frame_end
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lvgt_pkg::APB_AW-1:0] paddr,
    input  logic [lvgt_pkg::APB_DW-1:0] pwdata,
    output logic [lvgt_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int HALF  = (WINDOW - 1) / 2;
    localparam int AFTER = WINDOW - 1 - HALF;
    localparam int ROWS  = WINDOW + 1;
    localparam int DEPTH = ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(MAX_WIDTH + 1);
    localparam int SLW   = $clog2(ROWS);
    localparam int WIW   = $clog2(WINDOW);
    localparam int CELLS = WINDOW * WINDOW;
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int SUMW  = $clog2(CELLS * 255 + 1);
    localparam int VSUMW = $clog2(CELLS * 65025 + 1);
    localparam int FW_W  = lvgt_pkg::FW_W;
    localparam int FH_W  = lvgt_pkg::FH_W;
    localparam int VL_W  = lvgt_pkg::VL_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DSTART,
        ST_DWAIT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [VL_W-1:0] vl_reg;

    logic [COLW-1:0] cur_w_reg, in_col_reg, out_col_reg;
    logic [FH_W-1:0] cur_h_reg, in_row_reg, out_row_reg;
    logic [SLW-1:0]  in_slot_reg, out_slot_reg, slot_reg;
    logic            in_done_reg;
    logic [7:0]      held_reg;

    logic [WIW-1:0]  wi_reg, wj_reg;
    logic            iss_done_reg, pv_reg, pc_reg, plast_reg, pass2_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VSUMW-1:0] vsum_reg, var_reg;
    logic [7:0]      center_reg, mean_reg;

    logic            m_tvalid_reg, m_white_reg, m_row_end_reg, m_frame_end_reg;

    // ---------------- configuration port ----------------
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= lvgt_pkg::FW_RESET;
            fh_reg <= lvgt_pkg::FH_RESET;
            vl_reg <= lvgt_pkg::VL_RESET;
        end
        else if (cfg_we)
        begin
            case (lvgt_pkg::reg_idx_t'(paddr[3:2]))
                lvgt_pkg::REG_WIDTH:  fw_reg <= pwdata[FW_W-1:0];
                lvgt_pkg::REG_HEIGHT: fh_reg <= pwdata[FH_W-1:0];
                lvgt_pkg::REG_VLIMIT: vl_reg <= pwdata[VL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (lvgt_pkg::reg_idx_t'(paddr[3:2]))
            lvgt_pkg::REG_WIDTH:  prdata = lvgt_pkg::APB_DW'(fw_reg);
            lvgt_pkg::REG_HEIGHT: prdata = lvgt_pkg::APB_DW'(fh_reg);
            lvgt_pkg::REG_VLIMIT: prdata = lvgt_pkg::APB_DW'(vl_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    logic            accept, do_write, first_px;
    logic [COLW-1:0] eff_w, w_use;
    logic [FH_W-1:0] eff_h, h_use;
    logic [COLW:0]   col_inc;
    logic [FH_W:0]   row_inc;
    logic [AW-1:0]   waddr;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign do_write = accept && (s_tuser == lvgt_pkg::FUNC_PIXEL) && !in_done_reg;
    assign first_px = (in_row_reg == '0) && (in_col_reg == '0);
    assign eff_w    = (fw_reg == '0) ? COLW'(1) :
                      (32'(fw_reg) > MAX_WIDTH) ? COLW'(MAX_WIDTH) : COLW'(fw_reg);
    assign eff_h    = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    assign w_use    = first_px ? eff_w : cur_w_reg;
    assign h_use    = first_px ? eff_h : cur_h_reg;
    assign col_inc  = {1'b0, in_col_reg} + (COLW+1)'(1);
    assign row_inc  = {1'b0, in_row_reg} + (FH_W+1)'(1);
    assign waddr    = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    // ---------------- result readiness ----------------
    logic          pending, ready_res;
    logic [FH_W:0] nr_raw, nr;
    logic [COLW:0] nc_raw, nc;

    assign pending = in_done_reg || (in_row_reg != '0) || (in_col_reg != '0);
    assign nr_raw  = {1'b0, out_row_reg} + (FH_W+1)'(AFTER);
    assign nr      = (nr_raw > {1'b0, cur_h_reg} - (FH_W+1)'(1)) ?
                     {1'b0, cur_h_reg} - (FH_W+1)'(1) : nr_raw;
    assign nc_raw  = {1'b0, out_col_reg} + (COLW+1)'(AFTER);
    assign nc      = (nc_raw > {1'b0, cur_w_reg} - (COLW+1)'(1)) ?
                     {1'b0, cur_w_reg} - (COLW+1)'(1) : nc_raw;
    assign ready_res = in_done_reg || ({1'b0, in_row_reg} > nr) ||
                       (({1'b0, in_row_reg} == nr) && ({1'b0, in_col_reg} > nc));

    // ---------------- window scan ----------------
    logic [FH_W:0]  ru;
    logic [COLW:0]  cu;
    logic           row_ok, col_ok, cell_center, cell_last;
    logic [AW-1:0]  raddr;
    logic [7:0]     rdata;
    logic [SLW:0]   slot_start_raw;
    logic [SLW-1:0] slot_start, slot_inc;
    logic [7:0]     diff;
    logic [15:0]    sq;

    assign ru          = {1'b0, out_row_reg} + (FH_W+1)'(wi_reg);
    assign cu          = {1'b0, out_col_reg} + (COLW+1)'(wj_reg);
    assign row_ok      = (ru >= (FH_W+1)'(HALF)) &&
                         (ru < {1'b0, cur_h_reg} + (FH_W+1)'(HALF));
    assign col_ok      = (cu >= (COLW+1)'(HALF)) &&
                         (cu < {1'b0, cur_w_reg} + (COLW+1)'(HALF));
    assign cell_center = (wi_reg == WIW'(HALF)) && (wj_reg == WIW'(HALF));
    assign cell_last   = (wi_reg == WIW'(WINDOW - 1)) && (wj_reg == WIW'(WINDOW - 1));
    assign raddr       = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(cu - (COLW+1)'(HALF));

    assign slot_start_raw = (SLW+1)'(out_slot_reg) + (SLW+1)'(ROWS - HALF);
    assign slot_start     = (slot_start_raw >= (SLW+1)'(ROWS)) ?
                            SLW'(slot_start_raw - (SLW+1)'(ROWS)) : SLW'(slot_start_raw);
    assign slot_inc       = (slot_reg == SLW'(ROWS - 1)) ? '0 : slot_reg + SLW'(1);

    assign diff = (rdata >= mean_reg) ? rdata - mean_reg : mean_reg - rdata;
    assign sq   = diff * diff;

    lvgt_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (8)
    ) u_mem (
        .clk   (clk),
        .we    (do_write),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---------------- shared divider ----------------
    logic                  div_start;
    logic [VSUMW-1:0]      div_quo;
    lvgt_pkg::div_status_t div_st;

    assign div_start = (state_reg == ST_DSTART);

    lvgt_div #(
        .N (VSUMW),
        .D (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pass2_reg ? vsum_reg : VSUMW'(sum_reg)),
        .divisor  (cnt_reg),
        .quotient (div_quo),
        .status   (div_st)
    );

    // ---------------- result ----------------
    logic [7:0] thr;
    logic       last_col, last_row, emit_go;

    assign thr      = (32'(var_reg) >= 32'(vl_reg)) ? mean_reg :
                      (out_col_reg == '0) ? 8'd0 : held_reg;
    assign last_col = ({1'b0, out_col_reg} == {1'b0, cur_w_reg} - (COLW+1)'(1));
    assign last_row = ({1'b0, out_row_reg} == {1'b0, cur_h_reg} - (FH_W+1)'(1));
    assign emit_go  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_w_reg       <= COLW'(lvgt_pkg::FW_RESET);
            cur_h_reg       <= lvgt_pkg::FH_RESET;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            in_slot_reg     <= '0;
            in_done_reg     <= 1'b0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            out_slot_reg    <= '0;
            held_reg        <= '0;
            wi_reg          <= '0;
            wj_reg          <= '0;
            slot_reg        <= '0;
            iss_done_reg    <= 1'b0;
            pv_reg          <= 1'b0;
            pc_reg          <= 1'b0;
            plast_reg       <= 1'b0;
            pass2_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_white_reg     <= 1'b0;
            m_row_end_reg   <= 1'b0;
            m_frame_end_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !emit_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (do_write)
                        begin
                            cur_w_reg <= w_use;
                            cur_h_reg <= h_use;
                            if (col_inc >= {1'b0, w_use})
                            begin
                                in_col_reg  <= '0;
                                in_row_reg  <= FH_W'(row_inc);
                                in_slot_reg <= (in_slot_reg == SLW'(ROWS - 1)) ?
                                               '0 : in_slot_reg + SLW'(1);
                                if (row_inc >= {1'b0, h_use})
                                begin
                                    in_done_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                in_col_reg <= COLW'(col_inc);
                            end
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (pending && ready_res)
                    begin
                        wi_reg       <= '0;
                        wj_reg       <= '0;
                        slot_reg     <= slot_start;
                        iss_done_reg <= 1'b0;
                        pass2_reg    <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    if (!iss_done_reg)
                    begin
                        pv_reg    <= row_ok && col_ok;
                        pc_reg    <= cell_center;
                        plast_reg <= cell_last;
                        if (wj_reg == WIW'(WINDOW - 1))
                        begin
                            wj_reg   <= '0;
                            wi_reg   <= wi_reg + WIW'(1);
                            slot_reg <= slot_inc;
                        end
                        else
                        begin
                            wj_reg <= wj_reg + WIW'(1);
                        end
                        if (cell_last)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pv_reg    <= 1'b0;
                        plast_reg <= 1'b0;
                    end
                    if (plast_reg)
                    begin
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (div_st.done)
                    begin
                        if (!pass2_reg)
                        begin
                            wi_reg       <= '0;
                            wj_reg       <= '0;
                            slot_reg     <= slot_start;
                            iss_done_reg <= 1'b0;
                            pass2_reg    <= 1'b1;
                            state_reg    <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        held_reg        <= (last_col && last_row) ? 8'd0 : thr;
                        m_tvalid_reg    <= 1'b1;
                        m_white_reg     <= (thr <= center_reg);
                        m_row_end_reg   <= last_col;
                        m_frame_end_reg <= last_col && last_row;
                        if (last_col)
                        begin
                            out_col_reg <= '0;
                            if (last_row)
                            begin
                                out_row_reg  <= '0;
                                out_slot_reg <= '0;
                                in_row_reg   <= '0;
                                in_col_reg   <= '0;
                                in_slot_reg  <= '0;
                                in_done_reg  <= 1'b0;
                            end
                            else
                            begin
                                out_row_reg  <= out_row_reg + FH_W'(1);
                                out_slot_reg <= (out_slot_reg == SLW'(ROWS - 1)) ?
                                                '0 : out_slot_reg + SLW'(1);
                            end
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COLW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // accumulators and divider results; the count survives into the second pass
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CHECK)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            vsum_reg <= '0;
        end
        else if ((state_reg == ST_DWAIT) && div_st.done)
        begin
            sum_reg  <= '0;
            vsum_reg <= '0;
            if (!pass2_reg)
            begin
                mean_reg <= div_quo[7:0];
            end
            else
            begin
                var_reg <= div_quo;
            end
        end
        else if ((state_reg == ST_SCAN) && pv_reg)
        begin
            if (!pass2_reg)
            begin
                sum_reg <= sum_reg + SUMW'(rdata);
                cnt_reg <= cnt_reg + CNTW'(1);
                if (pc_reg)
                begin
                    center_reg <= rdata;
                end
            end
            else
            begin
                vsum_reg <= vsum_reg + VSUMW'(sq);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_white_reg};
    assign m_tlast  = m_row_end_reg;
    assign m_tuser  = m_frame_end_reg;

`ifndef ASSERT_OFF
    a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg < cur_h_reg)
        else $error("result row beyond frame height");

    a_out_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_col_reg < cur_w_reg)
        else $error("result column beyond frame width");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_frame_end_reg |-> m_row_end_reg)
        else $error("frame end without row end");

    a_div_idle_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !div_st.busy)
        else $error("divider busy while emitting");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> !$past(s_tready))
        else $error("input accepted during window scan");
`endif

endmodule

### bench/tb_local_variance_gated_threshold.sv
// Testbench for local_variance_gated_threshold: streams frames of grey pixels,
// predicts each binarized result in a behavioral model and checks it on the fly.
// Depends on lvgt_pkg and the block's RTL only.
module tb_local_variance_gated_threshold;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF  = (lvgt_pkg::WINDOW_DEF - 1) / 2;
    localparam int LROWS = lvgt_pkg::WINDOW_DEF + 1;
    localparam logic FUNC_FLUSH = ~lvgt_pkg::FUNC_PIXEL;
    localparam int SETTLE_CYCLES = 250;
    localparam int LIMIT_CYCLES  = 3000000;

    typedef struct packed
    {
        logic white;
        logic row_end;
        logic frame_end;
    } bin_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lvgt_pkg::APB_AW-1:0] paddr = '0;
    logic [lvgt_pkg::APB_DW-1:0] pwdata = '0;
    logic [lvgt_pkg::APB_DW-1:0] prdata;
    logic pready;

    local_variance_gated_threshold DUT (.*);

    // binarizer state mirror
    byte unsigned lines [LROWS][lvgt_pkg::MAX_WIDTH_DEF];
    int unsigned in_col, in_row, out_col, out_row, cur_w, cur_h;
    int unsigned cfg_width, cfg_height, cfg_vlimit;
    byte unsigned hold_thr;
    bit frame_in_done;

    bin_word_t expected_words [$];
    int unsigned errors = 0;
    int unsigned words_checked = 0;
    int unsigned frames_sent = 0;
    int unsigned pixels_sent = 0;
    int unsigned hold_len = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_off = 0;
    bit quiet = 1'b0;
    longint unsigned cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned width_eff();
        if (cfg_width == 0) return 1;
        if (cfg_width > lvgt_pkg::MAX_WIDTH_DEF) return lvgt_pkg::MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned height_eff();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic bit frame_busy();
        return frame_in_done || in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0;
    endfunction

    function automatic byte unsigned window_threshold();
        int unsigned sum, cnt, vsum, mean, var_w, p, d;
        int r, c;
        sum = 0;
        cnt = 0;
        vsum = 0;
        for (int i = 0; i < lvgt_pkg::WINDOW_DEF; i++)
            for (int j = 0; j < lvgt_pkg::WINDOW_DEF; j++)
            begin
                r = int'(out_row) + i - HALF;
                c = int'(out_col) + j - HALF;
                if (r >= 0 && c >= 0 && r < int'(cur_h) && c < int'(cur_w))
                begin
                    sum += lines[r % LROWS][c];
                    cnt++;
                end
            end
        if (cnt == 0) cnt = 1;
        mean = sum / cnt;
        for (int i = 0; i < lvgt_pkg::WINDOW_DEF; i++)
            for (int j = 0; j < lvgt_pkg::WINDOW_DEF; j++)
            begin
                r = int'(out_row) + i - HALF;
                c = int'(out_col) + j - HALF;
                if (r >= 0 && c >= 0 && r < int'(cur_h) && c < int'(cur_w))
                begin
                    p = lines[r % LROWS][c];
                    d = (p >= mean) ? p - mean : mean - p;
                    vsum += d * d;
                end
            end
        var_w = vsum / cnt;
        if (out_col == 0) hold_thr = 0;
        if (var_w >= cfg_vlimit) hold_thr = mean[7:0];
        return hold_thr;
    endfunction

    // one accepted word; returns 1 when it releases a result
    function automatic bit binarize_step(logic f, byte unsigned pix, output bin_word_t r);
        int unsigned nr, nc;
        byte unsigned thr;
        bit ready, last_col, last_row;
        r = '0;
        if (f == lvgt_pkg::FUNC_PIXEL && !frame_in_done)
        begin
            if (in_row == 0 && in_col == 0)
            begin
                cur_w = width_eff();
                cur_h = height_eff();
            end
            lines[in_row % LROWS][in_col] = pix;
            in_col++;
            if (in_col >= cur_w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= cur_h) frame_in_done = 1'b1;
            end
        end
        if (!(frame_in_done || in_row > 0 || in_col > 0)) return 1'b0;
        nr = out_row + (lvgt_pkg::WINDOW_DEF - 1 - HALF);
        if (nr > cur_h - 1) nr = cur_h - 1;
        nc = out_col + (lvgt_pkg::WINDOW_DEF - 1 - HALF);
        if (nc > cur_w - 1) nc = cur_w - 1;
        ready = frame_in_done || in_row > nr || (in_row == nr && in_col > nc);
        if (!ready) return 1'b0;
        thr = window_threshold();
        last_col = (out_col == cur_w - 1);
        last_row = (out_row == cur_h - 1);
        r.white = (thr <= lines[out_row % LROWS][out_col]);
        r.row_end = last_col;
        r.frame_end = last_col && last_row;
        if (last_col)
        begin
            out_col = 0;
            if (last_row)
            begin
                out_row = 0;
                in_row = 0;
                in_col = 0;
                frame_in_done = 1'b0;
                hold_thr = 0;
            end
            else
                out_row++;
        end
        else
            out_col++;
        return 1'b1;
    endfunction

    task automatic send_word(logic f, byte unsigned pix);
        bin_word_t r;
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= pix;
        do @(posedge clk); while (!s_tready);
        if (f == lvgt_pkg::FUNC_PIXEL) pixels_sent++;
        if (binarize_step(f, pix, r)) expected_words.push_back(r);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(lvgt_pkg::reg_idx_t idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lvgt_pkg::REG_WIDTH:  cfg_width = val & 32'h7FF;
            lvgt_pkg::REG_HEIGHT: cfg_height = val & 32'hFFFF;
            default:              cfg_vlimit = val & 32'hFFFF;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned vl);
        reg_write(lvgt_pkg::REG_WIDTH, w);
        reg_write(lvgt_pkg::REG_HEIGHT, h);
        reg_write(lvgt_pkg::REG_VLIMIT, vl);
    endtask

    // style: 0 random, 1 low contrast, 2 two-level, 3 gradient
    function automatic byte unsigned pick_pixel(int style, int unsigned k);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return 8'(120 + $urandom_range(0, 12));
            2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return 8'(k * 7);
        endcase
    endfunction

    // full frame, then drain; some drain ticks carry a pixel that gets dropped
    task automatic send_frame(int style, int unsigned drop_pct);
        int unsigned n;
        n = width_eff() * height_eff();
        for (int unsigned k = 0; k < n; k++)
            send_word(lvgt_pkg::FUNC_PIXEL, pick_pixel(style, k));
        while (frame_busy())
        begin
            if ($urandom_range(0, 99) < drop_pct)
                send_word(lvgt_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)));
            else
                send_word(FUNC_FLUSH, 8'($urandom_range(0, 255)));
        end
        frames_sent++;
        settle();
    endtask

    task automatic test_directed();
        set_geometry(4, 3, 0);
        send_word(FUNC_FLUSH, 8'hFF);   // nothing pending
        send_word(FUNC_FLUSH, 8'h00);
        foreach (lines[0][k])
            if (k < 12)
                send_word(lvgt_pkg::FUNC_PIXEL,
                          (k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hFF : 8'h55));
        send_word(lvgt_pkg::FUNC_PIXEL, 8'hAA);   // dropped during drain
        while (frame_busy()) send_word(FUNC_FLUSH, 8'h00);
        frames_sent++;
        settle();
        set_geometry(5, 2, 65025);
        send_frame(2, 30);
    endtask

    task automatic test_geometry_edges();
        set_geometry(0, 0, 1000);       // one-pixel frame
        send_frame(0, 0);
        reg_write(lvgt_pkg::REG_HEIGHT, 65535);
        reg_write(lvgt_pkg::REG_WIDTH, 1);
        reg_write(lvgt_pkg::REG_HEIGHT, 9);
        send_frame(0, 20);
        set_geometry(2047, 1, 65535);   // clamps to full width
        send_frame(3, 10);
    endtask

    task automatic test_backpressure();
        set_geometry(8, 6, 500);
        hold_len = 3000;
        send_frame(0, 10);
    endtask

    task automatic test_random_frames();
        int unsigned target, vl;
        target = pixels_sent + 400;
        while (pixels_sent < target)
        begin
            case ($urandom_range(0, 4))
                0: vl = 0;
                1: vl = 65025;
                2: vl = $urandom_range(0, 3000);
                default: vl = $urandom_range(0, 65535);
            endcase
            set_geometry($urandom_range(1, 14), $urandom_range(1, 11), vl);
            quiet = ($urandom_range(0, 5) == 0);
            send_frame($urandom_range(0, 3), $urandom_range(0, 15));
            quiet = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        bin_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result white=%0b row_end=%0b frame_end=%0b",
                         $time, m_tdata[0], m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (want.white !== m_tdata[0] || want.row_end !== m_tlast
                    || want.frame_end !== m_tuser)
                begin
                    $display("%0t: mismatch expected white=%0b row_end=%0b frame_end=%0b, got %0b %0b %0b",
                             $time, want.white, want.row_end, want.frame_end,
                             m_tdata[0], m_tlast, m_tuser);
                    errors++;
                end
            end
        end
        if (hold_len != hold_taken)
        begin
            hold_taken <= hold_len;
            hold_off <= hold_len;
            m_tready <= 1'b0;
        end
        else if (hold_off != 0)
        begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        cfg_width = lvgt_pkg::FW_RESET;
        cfg_height = lvgt_pkg::FH_RESET;
        cfg_vlimit = lvgt_pkg::VL_RESET;
        cur_w = lvgt_pkg::FW_RESET;
        cur_h = lvgt_pkg::FH_RESET;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        hold_thr = 0;
        frame_in_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_geometry_edges();
        test_backpressure();
        test_random_frames();
        settle();
        $display("covered %0d frames, %0d pixels, %0d results checked", frames_sent,
                 pixels_sent, words_checked);
        $display("geometry clamps, variance limit extremes, drain drops and output stall");
        if (errors == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
